// File: hdl/sfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stuffed frame decoder.
// Depends on nothing; every other file in hdl imports it.
package sfd_pkg;

  localparam logic [7:0] HDR_MARK    = 8'hFE;
  localparam logic [7:0] ESC_MARK    = 8'hFD;
  localparam logic [7:0] ESC_FD      = 8'h5D;
  localparam logic [7:0] ESC_FE      = 8'h5E;
  localparam logic [7:0] LEN_RESET   = 8'hF9;
  localparam logic [7:0] LEN_MIN     = 8'd3;
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;
  localparam logic [7:0] CHECK_BIAS  = 8'd3;

  localparam int SFD_QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_BAD_ESCAPE = 3'd3,
    ST_MISMATCH   = 3'd4
  } sfd_status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } sfd_phase_t;

  // One classified word passed from the front part to the back part.
  typedef struct packed {
    logic [7:0]  data;
    logic        is_check;
    logic        is_payload;
    logic        last;
    sfd_status_t status_pre;
  } sfd_token_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sfd_queue_status_t;

endpackage

// File: hdl/sfd_front.sv
`timescale 1ns / 1ps
// Front part: tracks the frame phase, checks header and length, and undoes escapes.
// Uses sfd_pkg; feeds classified words to sfd_queue.
module sfd_front
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] max_frame_length,
  output logic       push,
  output sfd_token_t token
);

  sfd_phase_t phase, phase_next;
  logic       header_good, header_good_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       escape_pending, escape_pending_next;
  logic       check_seen, check_seen_next;
  logic       escape_fault, escape_fault_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_good    <= 1'b0;
      bytes_left     <= 8'd0;
      escape_pending <= 1'b0;
      check_seen     <= 1'b0;
      escape_fault   <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      header_good    <= header_good_next;
      bytes_left     <= bytes_left_next;
      escape_pending <= escape_pending_next;
      check_seen     <= check_seen_next;
      escape_fault   <= escape_fault_next;
    end
  end

  logic       have;
  logic [7:0] decoded;

  always_comb begin
    phase_next          = phase;
    header_good_next    = header_good;
    bytes_left_next     = bytes_left;
    escape_pending_next = escape_pending;
    check_seen_next     = check_seen;
    escape_fault_next   = escape_fault;
    have                = 1'b0;
    decoded             = 8'd0;
    token.data          = 8'd0;
    token.is_check      = 1'b0;
    token.is_payload    = 1'b0;
    token.last          = 1'b0;
    token.status_pre    = ST_OK;
    case (phase)
      PH_LENGTH: begin
        phase_next = PH_HEADER;
        if (!header_good) begin
          token.last       = 1'b1;
          token.status_pre = ST_BAD_HEADER;
        end else if (rx_byte < LEN_MIN || rx_byte > max_frame_length) begin
          token.last       = 1'b1;
          token.status_pre = ST_BAD_LENGTH;
        end else begin
          phase_next          = PH_BODY;
          bytes_left_next     = rx_byte - LEN_OVERHEAD;
          escape_pending_next = 1'b0;
          check_seen_next     = 1'b0;
          escape_fault_next   = 1'b0;
        end
      end
      PH_BODY: begin
        bytes_left_next = bytes_left - 8'd1;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (rx_byte == ESC_FD) begin
            decoded = ESC_MARK;
            have    = 1'b1;
          end else if (rx_byte == ESC_FE) begin
            decoded = HDR_MARK;
            have    = 1'b1;
          end else begin
            escape_fault_next = 1'b1;
          end
        end else if (rx_byte == ESC_MARK) begin
          escape_pending_next = 1'b1;
        end else begin
          decoded = rx_byte;
          have    = 1'b1;
        end
        token.data       = decoded;
        token.is_check   = have && !check_seen;
        token.is_payload = have && check_seen;
        if (have) begin
          check_seen_next = 1'b1;
        end
        if (bytes_left_next == 8'd0) begin
          phase_next = PH_HEADER;
          token.last = 1'b1;
          if (escape_fault_next || escape_pending_next || !check_seen_next) begin
            token.status_pre = ST_BAD_ESCAPE;
          end
        end
      end
      default: begin
        header_good_next = (rx_byte == HDR_MARK);
        phase_next       = PH_LENGTH;
      end
    endcase
    push = accept && (token.is_check || token.is_payload || token.last);
  end

endmodule

// File: hdl/sfd_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of classified words between front and back.
// Uses sfd_pkg for the word type and status struct.
module sfd_queue
  import sfd_pkg::*;
#(
  parameter int DEPTH = SFD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfd_token_t        push_token,
  input  logic              pop,
  output sfd_token_t        head,
  output sfd_queue_status_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sfd_token_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             do_push, do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == FULL_CNT);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  always_comb begin
    count_next = count;
    case ({do_push, do_pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_token;
    end
  end

endmodule

// File: hdl/sfd_back.sv
`timescale 1ns / 1ps
// Back part: keeps the check byte and running xor, and drives the output register.
// Uses sfd_pkg; takes words from sfd_queue.
module sfd_back
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tok_valid,
  input  sfd_token_t  tok,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        frame_end,
  output logic [2:0]  status
);

  logic [7:0]  check_value, check_value_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  payload_count, payload_count_next;
  logic        tok_result, load;
  logic [7:0]  expected;
  sfd_status_t result_status;

  assign tok_result = tok.is_payload || tok.last;
  assign pop        = tok_valid && (!tok_result || !out_valid || !out_stall);
  assign load       = pop && tok_result;

  always_comb begin
    check_value_next   = check_value;
    running_xor_next   = running_xor;
    payload_count_next = payload_count;
    if (tok.is_check) begin
      check_value_next   = tok.data;
      running_xor_next   = 8'd0;
      payload_count_next = 8'd0;
    end else if (tok.is_payload) begin
      running_xor_next   = running_xor ^ tok.data;
      payload_count_next = payload_count + 8'd1;
    end
    expected = HDR_MARK ^ (payload_count_next + CHECK_BIAS) ^ running_xor_next;
    if (tok.status_pre != ST_OK) begin
      result_status = tok.status_pre;
    end else if (expected == check_value_next) begin
      result_status = ST_OK;
    end else begin
      result_status = ST_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_value   <= 8'd0;
      running_xor   <= 8'd0;
      payload_count <= 8'd0;
    end else if (pop) begin
      check_value   <= check_value_next;
      running_xor   <= running_xor_next;
      payload_count <= payload_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= tok.is_payload ? tok.data : 8'd0;
      has_byte  <= tok.is_payload;
      frame_end <= tok.last;
      status    <= tok.last ? result_status : ST_OK;
    end
  end

endmodule

// File: hdl/stuffed_frame_decoder.sv
`timescale 1ns / 1ps
// Top level of the byte-stuffed frame decoder with xor check byte.
// Uses sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
//   Channel  Signals                                    Direction
//   input    in_valid, in_stall, rx_byte                in (in_stall out)
//   output   out_valid, out_stall, out_byte, has_byte,  out (out_stall in)
//            frame_end, status
//   config   cfg_write, cfg_data                        in
//
// One received byte is taken per cycle while the output side keeps draining.
// A result goes from its byte through the queue and then the output register.
// Bytes that make no result do not load the output register.
// Reset is synchronous and returns to waiting for a header byte with
// max_frame_length at 249. in_stall rises only when the queue is full.
module stuffed_frame_decoder
  import sfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = SFD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       frame_end,
  output logic [2:0] status
);

  logic              [7:0] max_frame_length;
  logic              accept, push, pop;
  sfd_token_t        push_token, head;
  sfd_queue_status_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= LEN_RESET;
    end else if (cfg_write) begin
      max_frame_length <= cfg_data;
    end
  end

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  sfd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (rx_byte),
    .max_frame_length (max_frame_length),
    .push             (push),
    .token            (push_token)
  );

  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!qstat.empty),
    .tok       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .frame_end (frame_end),
    .status    (status)
  );

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_byte || frame_end))
    else $error("result word carries neither a byte nor a frame end");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (status == ST_OK))
    else $error("nonzero status outside a frame end");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !accept)
    else $error("byte accepted while the queue is full");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |=> !(out_valid && !$past(out_valid) && $past(qstat.empty)))
    else $error("output loaded from an empty queue");

endmodule
